FILE: sv/apa_pkg.sv
`timescale 1ns / 1ps
// apa_pkg: shared types, Q24 constants and rounding multiply for the atan2 pipeline
// no dependencies

package apa_pkg;

  localparam int QF    = 24;   // internal fraction bits
  localparam int QBITS = 23;   // quotient bits, |u| <= tan(pi/8) in Q24

  localparam logic [25:0] TAN_3PI8_Q = 26'd40503782;
  localparam logic [22:0] TAN_PI8_Q  = 23'd6949350;

  localparam logic signed [27:0] PI4_Q    = 28'sd13176795;
  localparam logic signed [27:0] PI2_Q    = 28'sd26353589;
  localparam logic signed [27:0] PI_Q     = 28'sd52707179;
  localparam logic signed [28:0] TWO_PI_Q = 29'sd105414357;

  typedef logic signed [25:0] q_t;

  localparam q_t C9_Q = 26'sd1351194;
  localparam q_t C7_Q = 26'sd2328289;
  localparam q_t C5_Q = 26'sd3351704;
  localparam q_t C3_Q = 26'sd5592341;

  // reduction region of the folded ratio ay/ax
  localparam logic [1:0] RGN_LOW  = 2'd0;
  localparam logic [1:0] RGN_MID  = 2'd1;
  localparam logic [1:0] RGN_HIGH = 2'd2;

  typedef struct packed {
    logic       xz;
    logic       yz;
    logic       yneg;
    logic       xneg;
    logic [1:0] rgn;
  } side_t;

  // floor(a*b / 2^24 + 1/2)
  function automatic q_t mulq(input q_t a, input q_t b);
    logic signed [51:0] pr;
    pr = a * b + 52'sd8388608;
    return pr[49:24];
  endfunction

endpackage

FILE: sv/atan2_polynomial_angle_top.sv
`timescale 1ns / 1ps
// atan2_polynomial_angle_top: angle of (y, x) in [0, 2pi) as unsigned Q3.F radians
// depends on apa_pkg, apa_prep, apa_div, apa_poly
//
//  channel | ports                               | dir | transfer when
//  in      | in_valid in_ready in_y/x_component  | in  | in_valid & in_ready
//  out     | out_valid out_ready out_angle       | out | out_valid & out_ready
//
// 35 register stages: 3 fold/region, 23 divider (one quotient bit each),
// 7 polynomial, 2 unfold/round; one item per cycle while the output is not stalled.
// each stage loads when empty or when the next stage moves, so bubbles close up
// and the input keeps taking items while a result waits at the output, as long as some stage is empty.
// rst_n (synchronous) clears only the stage valid bits.

module atan2_polynomial_angle_top #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COMPONENT_WIDTH-1:0] in_y_component,
  input  logic signed [COMPONENT_WIDTH-1:0] in_x_component,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ANGLE_FRAC_BITS+2:0]        out_angle
);
  import apa_pkg::*;

  localparam int W    = COMPONENT_WIDTH;
  localparam int F    = ANGLE_FRAC_BITS;
  localparam int NS   = 3 + QBITS + 9;
  localparam int DB   = 3;
  localparam int PB   = 3 + QBITS;
  localparam int FB   = PB + 7;
  localparam int SH   = QF - F;
  localparam logic [28:0] HALF = 29'(1) << (SH - 1);
  localparam logic [28:0] FULL = (29'(TWO_PI_Q) + HALF) >> SH;

  logic [NS-1:0] valid_r;
  logic [NS:0]   ld;

  always_comb begin
    ld[NS] = out_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      ld[i] = ~valid_r[i] | ld[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (ld[0]) valid_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (ld[i]) valid_r[i] <= valid_r[i-1];
      end
    end
  end

  logic [W+23:0]    num;
  logic [W:0]       den;
  logic             uneg_p, uneg_d;
  side_t            sd_p, sd_d, sd_q;
  logic [QBITS-1:0] quo;
  logic signed [27:0] t;

  apa_prep #(.W(W)) u_prep (
    .clk (clk), .ld (ld[2:0]), .y (in_y_component), .x (in_x_component),
    .num (num), .den (den), .uneg (uneg_p), .side (sd_p)
  );

  apa_div #(.W(W)) u_div (
    .clk (clk), .ld (ld[PB-1:DB]), .num (num), .den (den), .uneg (uneg_p),
    .side_in (sd_p), .quo (quo), .uneg_out (uneg_d), .side_out (sd_d)
  );

  apa_poly u_poly (
    .clk (clk), .ld (ld[FB-1:PB]), .quo (quo), .uneg (uneg_d),
    .side_in (sd_d), .t (t), .side_out (sd_q)
  );

  // unfold by quadrant, clamp at zero
  logic signed [28:0] a_nxt;
  logic [27:0]        a_r;
  logic [28:0]        res_sum, res_sh;
  logic [F+2:0]       angle_r;

  always_comb begin
    if (sd_q.xz) begin
      if (sd_q.yz)        a_nxt = '0;
      else if (!sd_q.yneg) a_nxt = 29'(PI2_Q);
      else                 a_nxt = 29'(PI_Q) + 29'(PI2_Q);
    end else if (!sd_q.xneg && !sd_q.yneg) begin
      a_nxt = 29'(t);
    end else if (sd_q.xneg && !sd_q.yneg) begin
      a_nxt = 29'(PI_Q) - 29'(t);
    end else if (sd_q.xneg) begin
      a_nxt = 29'(PI_Q) + 29'(t);
    end else begin
      a_nxt = TWO_PI_Q - 29'(t);
    end
  end

  assign res_sum = {1'b0, a_r} + HALF;
  assign res_sh  = res_sum >> SH;

  always_ff @(posedge clk) begin
    if (ld[FB]) a_r <= a_nxt[28] ? '0 : a_nxt[27:0];
    if (ld[FB+1]) begin
      angle_r <= (res_sh >= FULL) ? (F+3)'(res_sh - FULL) : (F+3)'(res_sh);
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = valid_r[NS-1];
  assign out_angle = angle_r;

`ifndef ASSERT_OFF
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({{(29-F-3){1'b0}}, out_angle} < FULL))
    else $error("angle at or above a full turn");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r[0] |-> in_ready)
    else $error("input stalled with empty first stage");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> valid_r[0])
    else $error("transfer lost at pipeline entry");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[NS-2] && out_valid && !out_ready) |=> valid_r[NS-2])
    else $error("stage dropped under output stall");
`endif

endmodule

FILE: sv/apa_prep.sv
`timescale 1ns / 1ps
// apa_prep: quadrant fold, region select by cross products, divider operands
// depends on apa_pkg

module apa_prep #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic [2:0]          ld,
  input  logic signed [W-1:0] y,
  input  logic signed [W-1:0] x,
  output logic [W+23:0]       num,
  output logic [W:0]          den,
  output logic                uneg,
  output apa_pkg::side_t      side
);
  import apa_pkg::*;

  logic [W-1:0]  ay0_r, ax0_r, ay1_r, ax1_r;
  side_t         sd0_r, sd1_r, sd2_r, sd2_nxt;
  logic [W+25:0] p3_r;
  logic [W+22:0] p1_r;
  logic [W+23:0] num_r, num_nxt;
  logic [W:0]    den_r, den_nxt;
  logic          uneg_r, uneg_nxt;
  logic [1:0]    rgn_nxt;
  logic [W+25:0] lhs;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      ay0_r     <= y[W-1] ? W'(-y) : W'(y);
      ax0_r     <= x[W-1] ? W'(-x) : W'(x);
      sd0_r.xz   <= (x == '0);
      sd0_r.yz   <= (y == '0);
      sd0_r.yneg <= y[W-1];
      sd0_r.xneg <= x[W-1];
      sd0_r.rgn  <= RGN_LOW;
    end
    if (ld[1]) begin
      ay1_r <= ay0_r;
      ax1_r <= ax0_r;
      p3_r  <= TAN_3PI8_Q * ax0_r;
      p1_r  <= TAN_PI8_Q * ax0_r;
      sd1_r <= sd0_r;
    end
    if (ld[2]) begin
      num_r  <= num_nxt;
      den_r  <= den_nxt;
      uneg_r <= uneg_nxt;
      sd2_r  <= sd2_nxt;
    end
  end

  always_comb begin
    lhs = {2'b00, ay1_r, 24'b0};
    if (lhs > p3_r) begin
      rgn_nxt  = RGN_HIGH;
      num_nxt  = {ax1_r, 24'b0};
      den_nxt  = {1'b0, ay1_r};
      uneg_nxt = 1'b1;
    end else if (lhs > {3'b000, p1_r}) begin
      rgn_nxt  = RGN_MID;
      den_nxt  = {1'b0, ay1_r} + {1'b0, ax1_r};
      uneg_nxt = (ay1_r < ax1_r);
      num_nxt  = uneg_nxt ? {ax1_r - ay1_r, 24'b0} : {ay1_r - ax1_r, 24'b0};
    end else begin
      rgn_nxt  = RGN_LOW;
      num_nxt  = {ay1_r, 24'b0};
      den_nxt  = {1'b0, ax1_r};
      uneg_nxt = 1'b0;
    end
    sd2_nxt     = sd1_r;
    sd2_nxt.rgn = rgn_nxt;
  end

  assign num  = num_r;
  assign den  = den_r;
  assign uneg = uneg_r;
  assign side = sd2_r;

endmodule

FILE: sv/apa_div.sv
`timescale 1ns / 1ps
// apa_div: pipelined restoring divider, one quotient bit per stage
// depends on apa_pkg

module apa_div #(
  parameter int W = 16
) (
  input  logic                          clk,
  input  logic [apa_pkg::QBITS-1:0]     ld,
  input  logic [W+23:0]                 num,
  input  logic [W:0]                    den,
  input  logic                          uneg,
  input  apa_pkg::side_t                side_in,
  output logic [apa_pkg::QBITS-1:0]     quo,
  output logic                          uneg_out,
  output apa_pkg::side_t                side_out
);
  import apa_pkg::*;

  logic [W+23:0]    rem_r  [QBITS];
  logic [W:0]       den_r  [QBITS];
  logic [QBITS-1:0] q_r    [QBITS];
  logic             uneg_r [QBITS];
  side_t            sd_r   [QBITS];

  for (genvar j = 0; j < QBITS; j++) begin : g_stage
    localparam int B = QBITS - 1 - j;
    logic [W+23:0]    rem_in, trial;
    logic [W:0]       den_in;
    logic [QBITS-1:0] q_in;
    logic             uneg_in;
    side_t            sd_in;
    logic             ge;

    if (j == 0) begin : g_first
      assign rem_in  = num;
      assign den_in  = den;
      assign q_in    = '0;
      assign uneg_in = uneg;
      assign sd_in   = side_in;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign den_in  = den_r[j-1];
      assign q_in    = q_r[j-1];
      assign uneg_in = uneg_r[j-1];
      assign sd_in   = sd_r[j-1];
    end

    assign trial = (W+24)'(den_in) << B;
    assign ge    = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (ld[j]) begin
        rem_r[j]  <= ge ? rem_in - trial : rem_in;
        den_r[j]  <= den_in;
        q_r[j]    <= q_in | (QBITS'(ge) << B);
        uneg_r[j] <= uneg_in;
        sd_r[j]   <= sd_in;
      end
    end
  end

  assign quo      = q_r[QBITS-1];
  assign uneg_out = uneg_r[QBITS-1];
  assign side_out = sd_r[QBITS-1];

endmodule

FILE: sv/apa_poly.sv
`timescale 1ns / 1ps
// apa_poly: odd degree-9 polynomial on the reduced argument plus region offset
// depends on apa_pkg

module apa_poly (
  input  logic                      clk,
  input  logic [6:0]                ld,
  input  logic [apa_pkg::QBITS-1:0] quo,
  input  logic                      uneg,
  input  apa_pkg::side_t            side_in,
  output logic signed [27:0]        t,
  output apa_pkg::side_t            side_out
);
  import apa_pkg::*;

  q_t    u_r [6];
  q_t    z_r [1:4];
  q_t    p2_r, p3_r, p4_r, m5_r;
  side_t sd_r [7];
  logic signed [27:0] t_r, off;

  always_comb begin
    case (sd_r[5].rgn)
      RGN_HIGH: off = PI2_Q;
      RGN_MID:  off = PI4_Q;
      default:  off = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      u_r[0]  <= uneg ? -q_t'({3'b000, quo}) : q_t'({3'b000, quo});
      sd_r[0] <= side_in;
    end
    for (int i = 1; i < 6; i++) begin
      if (ld[i]) begin
        u_r[i]  <= u_r[i-1];
        sd_r[i] <= sd_r[i-1];
      end
    end
    for (int i = 2; i < 5; i++) begin
      if (ld[i]) z_r[i] <= z_r[i-1];
    end
    if (ld[1]) z_r[1] <= mulq(u_r[0], u_r[0]);
    if (ld[2]) p2_r <= mulq(C9_Q, z_r[1]) - C7_Q;
    if (ld[3]) p3_r <= mulq(p2_r, z_r[2]) + C5_Q;
    if (ld[4]) p4_r <= mulq(p3_r, z_r[3]) - C3_Q;
    if (ld[5]) m5_r <= mulq(p4_r, z_r[4]);
    if (ld[6]) begin
      t_r     <= off + 28'(u_r[5]) + 28'(mulq(m5_r, u_r[5]));
      sd_r[6] <= sd_r[5];
    end
  end

  assign t        = t_r;
  assign side_out = sd_r[6];

endmodule
